>>> rtl/core/bcmp_pkg.sv
// Shared types and constants of the binomial coefficient modulo p block.
`default_nettype none

package bcmp_pkg;

    // Field widths of the request and result transactions.
    localparam int N_W    = 10;
    localparam int COEF_W = 31;

    // Modulus after reset, and the smallest modulus the datapath accepts.
    localparam logic [COEF_W-1:0] MODULUS_RESET = 31'd1000000007;
    localparam logic [COEF_W-1:0] MODULUS_MIN   = 31'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;     // latch n and r of an accepted request
        logic check;    // preset the trivial result and the row counter
        logic row_start; // open a row: column 1, left neighbor 1, read column 1
        logic calc;     // compute and write one table entry
        logic fetch;    // read column r of the final row
        logic capture;  // keep the fetched entry as result
        logic emit;     // move the result into the output register
    } bcmp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic trivial_zero; // r above n, or n beyond the row store
        logic trivial_one;  // r equal to 0 or to n
        logic row_done;     // current column is the last one of the row
        logic last_row;     // current row is row n
        logic out_free;     // output register can take a result this cycle
    } bcmp_stat_t;

endpackage

`default_nettype wire

>>> rtl/core/bcmp_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module bcmp_ram #(
    parameter int WIDTH = 31,
    parameter int DEPTH = 1024
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

>>> rtl/core/bcmp_ctrl.sv
// Controller state machine that sequences rows and columns of Pascal's table.
`default_nettype none

module bcmp_ctrl (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire bcmp_pkg::bcmp_stat_t stat,
    output bcmp_pkg::bcmp_cmd_t      cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_ROW   = 3'd2;
    localparam logic [2:0] S_CELL  = 3'd3;
    localparam logic [2:0] S_FETCH = 3'd4;
    localparam logic [2:0] S_LOAD  = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    // Next state and commands.
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
                if (s_valid) begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                cmd.check = 1'b1;
                if (stat.trivial_zero || stat.trivial_one) begin
                    state_next = S_OUT;
                end else begin
                    state_next = S_ROW;
                end
            end
            S_ROW: begin
                cmd.row_start = 1'b1;
                state_next    = S_CELL;
            end
            S_CELL: begin
                cmd.calc = 1'b1;
                if (stat.row_done) begin
                    state_next = stat.last_row ? S_FETCH : S_ROW;
                end
            end
            S_FETCH: begin
                cmd.fetch  = 1'b1;
                state_next = S_LOAD;
            end
            S_LOAD: begin
                cmd.capture = 1'b1;
                state_next  = S_OUT;
            end
            S_OUT: begin
                cmd.emit = stat.out_free;
                if (stat.out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/bcmp_dp.sv
// Datapath: request registers, row and column counters, modular adder, row store.
`default_nettype none

module bcmp_dp #(
    parameter int MAX_N = 1023
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic [bcmp_pkg::N_W-1:0]      s_n_value,
    input  wire logic [bcmp_pkg::N_W-1:0]      s_r_value,
    input  wire logic                          cfg_valid,
    input  wire logic [bcmp_pkg::COEF_W-1:0]   cfg_data,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic      [bcmp_pkg::COEF_W-1:0]   m_coefficient,
    input  wire bcmp_pkg::bcmp_cmd_t           cmd,
    output bcmp_pkg::bcmp_stat_t               stat
);

    localparam int DEPTH = MAX_N + 1;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [16:0] MAX_N_V = 17'(MAX_N);

    logic [bcmp_pkg::N_W-1:0]    n_reg, r_reg, i_reg, j_reg;
    logic [bcmp_pkg::COEF_W-1:0] prev_reg, res_reg, mod_reg, m_coef_reg;
    logic                        m_valid_reg;

    logic [bcmp_pkg::N_W-1:0]    top;
    logic [bcmp_pkg::COEF_W-1:0] rd_data, cell_val;
    logic [bcmp_pkg::COEF_W:0]   sum, diff;
    logic [AW-1:0]               rd_addr, wr_addr;

    // Last column of the current row: min(i, r).
    assign top = (i_reg < r_reg) ? i_reg : r_reg;

    // Status toward the controller.
    always_comb begin
        stat.trivial_zero = (r_reg > n_reg) || (17'(n_reg) > MAX_N_V);
        stat.trivial_one  = (r_reg == '0) || (r_reg == n_reg);
        stat.row_done     = (j_reg == top);
        stat.last_row     = (i_reg == n_reg);
        stat.out_free     = !m_valid_reg || m_ready;
    end

    // Modular sum of the entry above and its left neighbor; diagonal entries are 1.
    assign sum  = {1'b0, rd_data} + {1'b0, prev_reg};
    assign diff = sum - {1'b0, mod_reg};
    always_comb begin
        if (j_reg == i_reg) begin
            cell_val = bcmp_pkg::COEF_W'(1);
        end else if (sum >= {1'b0, mod_reg}) begin
            cell_val = diff[bcmp_pkg::COEF_W-1:0];
        end else begin
            cell_val = sum[bcmp_pkg::COEF_W-1:0];
        end
    end

    // Read address: next column during a row, column r at the end, else column 1.
    always_comb begin
        if (cmd.fetch) begin
            rd_addr = AW'(r_reg);
        end else if (cmd.calc && !stat.row_done) begin
            rd_addr = AW'(j_reg + bcmp_pkg::N_W'(1));
        end else begin
            rd_addr = AW'(1);
        end
    end
    assign wr_addr = AW'(j_reg);

    bcmp_ram #(
        .WIDTH (bcmp_pkg::COEF_W),
        .DEPTH (DEPTH)
    ) u_row_store (
        .aclk    (aclk),
        .wr_en   (cmd.calc),
        .wr_addr (wr_addr),
        .wr_data (cell_val),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Control state: output valid and the modulus register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            mod_reg     <= bcmp_pkg::MODULUS_RESET;
        end else begin
            if (cmd.emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            // Clamp a modulus below two up to two.
            if (cfg_valid) begin
                mod_reg <= (cfg_data < bcmp_pkg::MODULUS_MIN) ? bcmp_pkg::MODULUS_MIN
                                                              : cfg_data;
            end
        end
    end

    // Payload registers and counters.
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            n_reg <= s_n_value;
            r_reg <= s_r_value;
        end
        if (cmd.check) begin
            i_reg   <= bcmp_pkg::N_W'(1);
            res_reg <= stat.trivial_zero ? '0 : bcmp_pkg::COEF_W'(1);
        end
        if (cmd.row_start) begin
            j_reg    <= bcmp_pkg::N_W'(1);
            prev_reg <= bcmp_pkg::COEF_W'(1);
        end
        if (cmd.calc) begin
            prev_reg <= rd_data;
            if (stat.row_done) begin
                i_reg <= i_reg + bcmp_pkg::N_W'(1);
            end else begin
                j_reg <= j_reg + bcmp_pkg::N_W'(1);
            end
        end
        if (cmd.capture) begin
            res_reg <= rd_data;
        end
        if (cmd.emit) begin
            m_coef_reg <= res_reg;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_coefficient = m_coef_reg;

endmodule

`default_nettype wire

>>> rtl/core/binomial_coefficient_mod_p.sv
// Top level of the binomial coefficient modulo p block.
//
// Returns C(n, r) mod modulus for each request, building Pascal's triangle row by
// row in a row store of MAX_N+1 words; only columns 1..min(i, r) of row i are kept.
// Requests are handled one at a time. When r exceeds n (or n exceeds MAX_N), or r
// is 0 or n, the result is preset and no table is built; otherwise rows 1..n are
// built in turn. The run time is set by the row store: each entry takes one read
// and one write of its single-port-write RAM, and each row opens with a row-start
// step that turns the read order around. A finished result is held, with the
// controller in S_OUT, while the output register is still full, and no new request
// is taken until it moves on. The row store needs no clearing after reset, since no
// entry is used before it is written. A modulus below 2 is taken as 2; write it only
// while no request is in flight.
`default_nettype none

module binomial_coefficient_mod_p #(
    parameter int MAX_N = 1023
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic [bcmp_pkg::N_W-1:0]    s_n_value,
    input  wire logic [bcmp_pkg::N_W-1:0]    s_r_value,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic      [bcmp_pkg::COEF_W-1:0] m_coefficient,
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [bcmp_pkg::COEF_W-1:0] cfg_data
);

    bcmp_pkg::bcmp_cmd_t  cmd;
    bcmp_pkg::bcmp_stat_t stat;

    // Configuration is taken at any time.
    assign cfg_ready = 1'b1;

    bcmp_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    bcmp_dp #(
        .MAX_N (MAX_N)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_n_value     (s_n_value),
        .s_r_value     (s_r_value),
        .cfg_valid     (cfg_valid && cfg_ready),
        .cfg_data      (cfg_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_coefficient (m_coefficient),
        .cmd           (cmd),
        .stat          (stat)
    );

    // One request in flight: no second transaction right after an accepted one.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("request accepted while one is in flight");

    // Row store is written only while a request is in flight.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.calc |-> !s_ready)
        else $error("row store written while idle");

    // An emitted result shows up on the output channel.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |=> m_valid)
        else $error("emitted result not presented");

endmodule

`default_nettype wire

>>> dv/tb.sv
// Self-checking testbench of binomial_coefficient_mod_p: n choose r modulo a register value.
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_W                    = bcmp_pkg::N_W;
    localparam int COEF_W                 = bcmp_pkg::COEF_W;
    localparam logic [COEF_W-1:0] MODULUS_RESET = bcmp_pkg::MODULUS_RESET;

    localparam int MAX_N        = 1023;
    localparam int CFG_MODULUS  = 0;     // the only register of the configuration port
    localparam int HOLD_CYCLES  = 20000; // long receiver hold-off
    localparam int ITEMS_PHASE  = 10;
    localparam int NUM_DIRECTED = 24;

    // One directed request; known rows carry a coefficient typed in by hand.
    typedef struct packed {
        logic [N_W-1:0]    n;
        logic [N_W-1:0]    r;
        logic              known;
        logic [COEF_W-1:0] coef;
    } req_row_t;

    // One coefficient waiting for its result transaction.
    typedef struct packed {
        logic [N_W-1:0]    n;
        logic [N_W-1:0]    r;
        logic [COEF_W-1:0] coef;
    } coef_entry_t;

    localparam req_row_t DIRECTED [NUM_DIRECTED] = '{
        '{10'd0,    10'd0,    1'b1, 31'd1},
        '{10'd0,    10'd1023, 1'b1, 31'd0},
        '{10'd1023, 10'd0,    1'b1, 31'd1},
        '{10'd1023, 10'd1023, 1'b1, 31'd1},
        '{10'd1022, 10'd1023, 1'b1, 31'd0},
        '{10'd5,    10'd7,    1'b1, 31'd0},
        '{10'd1,    10'd1,    1'b1, 31'd1},
        '{10'd1,    10'd0,    1'b1, 31'd1},
        '{10'd2,    10'd1,    1'b1, 31'd2},
        '{10'd10,   10'd9,    1'b1, 31'd10},
        '{10'd1023, 10'd1,    1'b1, 31'd1023},
        '{10'd512,  10'd0,    1'b1, 31'd1},
        '{10'd341,  10'd341,  1'b1, 31'd1},
        '{10'd0,    10'd682,  1'b1, 31'd0},
        '{10'd681,  10'd682,  1'b1, 31'd0},
        '{10'd4,    10'd2,    1'b0, 31'd0},
        '{10'd10,   10'd5,    1'b0, 31'd0},
        '{10'd30,   10'd15,   1'b0, 31'd0},
        '{10'd40,   10'd20,   1'b0, 31'd0},
        '{10'd48,   10'd24,   1'b0, 31'd0},
        '{10'd682,  10'd3,    1'b0, 31'd0},
        '{10'd1023, 10'd2,    1'b0, 31'd0},
        '{10'd1023, 10'd200,  1'b0, 31'd0},
        '{10'd33,   10'd32,   1'b0, 31'd0}
    };

    logic              aclk          = 1'b0;
    logic              aresetn       = 1'b0;
    logic              s_valid       = 1'b0;
    logic              s_ready;
    logic [N_W-1:0]    s_n_value     = '0;
    logic [N_W-1:0]    s_r_value     = '0;
    logic              m_valid;
    logic              m_ready       = 1'b0;
    logic [COEF_W-1:0] m_coefficient;
    logic              cfg_valid     = 1'b0;
    logic              cfg_ready;
    logic [COEF_W-1:0] cfg_data      = '0;

    logic [COEF_W-1:0] coef_modulus  = MODULUS_RESET;
    logic [COEF_W-1:0] pascal_row [0:MAX_N];
    coef_entry_t       coef_queue [$];

    int  err_count   = 0;
    int  req_count   = 0;
    int  coef_count  = 0;
    int  cfg_count   = 0;
    int  burst_left  = 0;
    bit  hold_req    = 1'b0;

    binomial_coefficient_mod_p #(.MAX_N(MAX_N)) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_n_value     (s_n_value),
        .s_r_value     (s_r_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_coefficient (m_coefficient),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // Build Pascal's triangle up to row n, columns 0..r, reducing every sum.
    function automatic logic [COEF_W-1:0] binom_mod(input logic [N_W-1:0] n,
                                                    input logic [N_W-1:0] r,
                                                    input logic [COEF_W-1:0] mod_reg);
        logic [COEF_W:0] m;
        logic [COEF_W:0] s;
        int i;
        int j;
        int top;
        m = {1'b0, mod_reg};
        if (m < 2) begin
            m = (COEF_W+1)'(2);
        end
        if (r > n) begin
            return '0;
        end
        pascal_row[0] = COEF_W'(1);
        for (i = 1; i <= int'(n); i++) begin
            top = (i < int'(r)) ? i : int'(r);
            for (j = top; j >= 1; j--) begin
                if (j == i) begin
                    pascal_row[j] = COEF_W'(1);
                end else begin
                    s = ({1'b0, pascal_row[j]} % m) + ({1'b0, pascal_row[j-1]} % m);
                    if (s >= m) begin
                        s = s - m;
                    end
                    pascal_row[j] = s[COEF_W-1:0];
                end
            end
            pascal_row[0] = COEF_W'(1);
        end
        return pascal_row[r];
    endfunction

    task automatic report_mismatch(input string what, input coef_entry_t want,
                                   input logic [COEF_W-1:0] got);
        $display("mismatch: %s n=%0d r=%0d got %0d want %0d",
                 what, want.n, want.r, got, want.coef);
        err_count++;
    endtask

    // Offer one request, in bursts with random gaps, and queue its coefficient.
    task automatic send_request(input logic [N_W-1:0] n, input logic [N_W-1:0] r,
                                input logic known, input logic [COEF_W-1:0] coef);
        int gap;
        coef_entry_t entry;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 10);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_valid   <= 1'b1;
        s_n_value <= n;
        s_r_value <= r;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        entry.n    = n;
        entry.r    = r;
        entry.coef = known ? coef : binom_mod(n, r, coef_modulus);
        coef_queue.push_back(entry);
        req_count++;
    endtask

    // Drain every outstanding coefficient, then let the block settle.
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (coef_queue.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_modulus(input logic [COEF_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid    <= 1'b0;
        coef_modulus = value;
        cfg_count++;
    endtask

    // Mostly small full tables, plus trivial cases over the whole field range and long narrow tables.
    task automatic run_random(input int count);
        logic [N_W-1:0] n;
        logic [N_W-1:0] r;
        int pick;
        repeat (count) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                n = N_W'($urandom_range(0, 48));
                r = N_W'($urandom_range(0, n));
            end else if (pick < 70) begin
                n = N_W'($urandom_range(0, MAX_N - 1));
                r = N_W'($urandom_range(n + 1, MAX_N));
            end else if (pick < 78) begin
                n = N_W'($urandom_range(0, MAX_N));
                r = '0;
            end else if (pick < 86) begin
                n = N_W'($urandom_range(0, MAX_N));
                r = n;
            end else begin
                n = N_W'($urandom);
                r = N_W'($urandom);
                // keep a long table cheap: few columns only
                if (r < n && r != 0 && r > 3) begin
                    r = N_W'($urandom_range(1, 3));
                end
            end
            send_request(n, r, 1'b0, '0);
        end
    endtask

    // Check each result transaction against the oldest queued coefficient.
    always @(posedge aclk) begin
        coef_entry_t want;
        if (aresetn && m_valid && m_ready) begin
            coef_count++;
            if (coef_queue.size() == 0) begin
                want = '0;
                report_mismatch("unexpected coefficient", want, m_coefficient);
            end else begin
                want = coef_queue.pop_front();
                if (m_coefficient !== want.coef) begin
                    report_mismatch("coefficient", want, m_coefficient);
                end
            end
        end
    end

    // Receiver: segments of always ready, random stalls and sparse ready, plus one long hold.
    initial begin
        int mode;
        int seg_left;
        seg_left = 0;
        mode     = 0;
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_req = 1'b0;
            end else begin
                if (seg_left == 0) begin
                    mode     = $urandom_range(0, 2);
                    seg_left = $urandom_range(5, 60);
                end
                seg_left--;
                case (mode)
                    0: begin
                        m_ready <= 1'b1;
                    end
                    1: begin
                        m_ready <= ($urandom_range(0, 1) == 1);
                    end
                    default: begin
                        m_ready <= ($urandom_range(0, 3) == 0);
                    end
                endcase
                @(posedge aclk);
            end
        end
    end

    // Limit the run well beyond the slowest legal schedule.
    initial begin
        #5ms;
        $display("tb: errors");
        $finish;
    end

    initial begin
        logic [COEF_W-1:0] moduli [8];
        moduli[0] = 31'h7FFF_FFFF;
        moduli[1] = 31'd2;
        moduli[2] = 31'd0;
        moduli[3] = 31'd1;
        moduli[4] = 31'd13;
        moduli[5] = COEF_W'($urandom_range(2, 32'h7FFF_FFFF));
        moduli[6] = COEF_W'($urandom_range(3, 200));
        moduli[7] = MODULUS_RESET;

        // Hold reset, then release it at a clock edge.
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed requests under the modulus after reset.
        for (int k = 0; k < NUM_DIRECTED; k++) begin
            send_request(DIRECTED[k].n, DIRECTED[k].r, DIRECTED[k].known, DIRECTED[k].coef);
        end
        wait_drained();

        // Random requests under each modulus setting; hold the receiver in the first.
        for (int p = 0; p < 8; p++) begin
            write_modulus(moduli[p]);
            if (p == 0) begin
                hold_req = 1'b1;
            end
            run_random(ITEMS_PHASE);
            wait_drained();
        end

        repeat (20) @(posedge aclk);
        if (coef_queue.size() != 0) begin
            $display("mismatch: %0d coefficients never arrived", coef_queue.size());
            err_count++;
        end
        $display("summary: %0d requests, %0d coefficients, %0d modulus writes (%0d mismatches)",
                 req_count, coef_count, cfg_count, err_count);
        $display("summary: moduli 0, 1, 2, 13, small, random, 2^31-1 and reset value");
        if (err_count == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

endmodule

`default_nettype wire

>>> binomial_coefficient_mod_p.f
rtl/core/bcmp_pkg.sv
rtl/core/bcmp_ram.sv
rtl/core/bcmp_ctrl.sv
rtl/core/bcmp_dp.sv
rtl/core/binomial_coefficient_mod_p.sv
dv/tb.sv
